### hdl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro takes the label, the antecedent and the consequent, and is
// clocked by clk with the check held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCVW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcvw assertion failed");

// Next-cycle implication.
`define TCVW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcvw assertion failed");

`endif

### hdl/tcvw_pkg.sv
// ----------------------------------------------------------------------------
// tcvw_pkg
// Types, constants and helpers shared by the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcvw_pkg;

  // Field widths
  localparam int KIND_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 8;
  localparam int COLOR_W = 4;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 3;
  localparam int ADDR_W  = 14;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 5;
  localparam int BCD_W   = 20;
  localparam int BITCNT_W = 5;

  // Console geometry
  localparam int ROWS = 24;
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [POS_W-1:0] ROW_CLAMP = POS_W'(ROWS - 1);

  // Video memory map
  localparam logic [ADDR_W-1:0] NAME_BASE  = 14'h0800;
  localparam logic [ADDR_W-1:0] COLOR_BASE = 14'h0B00;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;
  localparam logic [CHAR_W-1:0] ALPHA_A   = 8'h41;

  localparam logic [COUNT_W-1:0] MAX_DIGITS = 3'd5;
  localparam logic [BITCNT_W-1:0] CONV_STEPS = BITCNT_W'(VALUE_W);
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd7;

  // Command kinds
  localparam logic [KIND_W-1:0] K_PUT    = 3'd0;
  localparam logic [KIND_W-1:0] K_PUT_AT = 3'd1;
  localparam logic [KIND_W-1:0] K_COLOUR = 3'd2;
  localparam logic [KIND_W-1:0] K_MOVE   = 3'd3;
  localparam logic [KIND_W-1:0] K_HEX    = 3'd4;
  localparam logic [KIND_W-1:0] K_DEC    = 3'd5;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_COLOUR,
    WR_HEX,
    WR_DEC
  } wr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_COLOUR,
    ST_CHAR,
    ST_HEX,
    ST_CONV,
    ST_DEC
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [COLOR_W-1:0] color;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } cmd_t;

  typedef struct packed {
    logic    load;
    logic    newline;
    logic    place;
    wr_sel_t wr;
    logic    conv_start;
    logic    conv_step;
    logic    dec_skip;
  } ctl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_newline;
    logic              count_zero;
    logic              idx_zero;
    logic              conv_last;
    logic              out_free;
    logic              dec_emit;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib > 4'd9) ch = ALPHA_A + {4'b0, nib} - 8'd10;
    else            ch = ZERO_CHAR + {4'b0, nib};
    return ch;
  endfunction

endpackage

`default_nettype wire

### hdl/tcvw_cmd_if.sv
// ----------------------------------------------------------------------------
// tcvw_cmd_if
// Console command channel: valid/ready plus one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcvw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tcvw_pkg::KIND_W-1:0]  kind;
  logic [tcvw_pkg::CHAR_W-1:0]  char_code;
  logic [tcvw_pkg::POS_W-1:0]   column;
  logic [tcvw_pkg::POS_W-1:0]   row;
  logic [tcvw_pkg::COLOR_W-1:0] color;
  logic [tcvw_pkg::VALUE_W-1:0] value;
  logic [tcvw_pkg::COUNT_W-1:0] digit_count;

  modport source (output valid, kind, char_code, column, row, color, value,
                  digit_count, input ready);
  modport sink (input valid, kind, char_code, column, row, color, value,
                digit_count, output ready);
endinterface

`default_nettype wire

### hdl/tcvw_wr_if.sv
// ----------------------------------------------------------------------------
// tcvw_wr_if
// Video memory write channel: valid/ready plus address, data and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcvw_wr_if;
  logic                        valid;
  logic                        ready;
  logic [tcvw_pkg::ADDR_W-1:0] vram_address;
  logic [tcvw_pkg::CHAR_W-1:0] vram_data;
  logic                        last;

  modport source (output valid, vram_address, vram_data, last, input ready);
  modport sink (input valid, vram_address, vram_data, last, output ready);
endinterface

`default_nettype wire

### hdl/tcvw_cfg_if.sv
// ----------------------------------------------------------------------------
// tcvw_cfg_if
// Configuration write channel for the background colour register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcvw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tcvw_pkg::COLOR_W-1:0] background_color;

  modport source (output valid, background_color, input ready);
  modport sink (input valid, background_color, output ready);
endinterface

`default_nettype wire

### hdl/tcvw_dp.sv
// ----------------------------------------------------------------------------
// tcvw_dp
// Datapath: command latch, cursor, BCD converter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcvw_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tcvw_pkg::cmd_t               cmd_in,
  input  wire logic                         cfg_we,
  input  wire logic [tcvw_pkg::COLOR_W-1:0] cfg_bg,
  input  wire tcvw_pkg::ctl_cmd_t           ctl,
  output tcvw_pkg::dp_status_t              status,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [tcvw_pkg::ADDR_W-1:0]       out_addr,
  output logic [tcvw_pkg::CHAR_W-1:0]       out_data,
  output logic                              out_last
);
  import tcvw_pkg::*;

  // Latched command
  logic [KIND_W-1:0]  kind_r;
  logic [CHAR_W-1:0]  char_r;
  logic [POS_W-1:0]   col_in_r;
  logic [POS_W-1:0]   row_in_r;
  logic [COLOR_W-1:0] color_r;
  logic [VALUE_W-1:0] value_r;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               count_zero_r;
  logic               started_r;

  // Console state
  logic [COLOR_W-1:0] bg_r;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;

  // BCD converter
  logic [BCD_W-1:0]    bcd_r, bcd_adj;
  logic [VALUE_W-1:0]  bin_r;
  logic [BITCNT_W-1:0] bit_cnt_r;

  // Output register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r, addr_nxt;
  logic [CHAR_W-1:0] out_data_r, data_nxt;
  logic              out_last_r, last_nxt;

  logic [COUNT_W-1:0]      sat_count;
  logic [BCD_W-1:0]        hex_src;
  logic [3:0]              hex_nib;
  logic [3:0]              dec_digit;
  logic                    out_free;
  logic                    advance;

  assign sat_count = (cmd_in.digit_count > MAX_DIGITS) ? MAX_DIGITS : cmd_in.digit_count;
  assign hex_src   = {4'b0, value_r};
  assign hex_nib   = hex_src[{idx_r, 2'b00} +: 4];
  assign dec_digit = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = (ctl.wr == WR_CHAR) || (ctl.wr == WR_HEX) || (ctl.wr == WR_DEC);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind_r   <= cmd_in.kind;
      char_r   <= cmd_in.char_code;
      col_in_r <= cmd_in.column;
      row_in_r <= cmd_in.row;
      color_r  <= cmd_in.color;
      value_r  <= cmd_in.value;
      count_zero_r <= (cmd_in.digit_count == '0);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.load) idx_nxt = sat_count - 3'd1;
    else if (ctl.wr == WR_HEX || ctl.wr == WR_DEC || ctl.dec_skip) idx_nxt = idx_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      started_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (ctl.load)              started_r <= 1'b0;
      else if (ctl.wr == WR_DEC) started_r <= 1'b1;
    end
  end

  // Cursor: newline, absolute placement, or advance after a character
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (ctl.newline) begin
      cur_col_nxt = '0;
      if (cur_row_r != LAST_ROW) cur_row_nxt = cur_row_r + 5'd1;
    end else if (ctl.place) begin
      cur_col_nxt = col_in_r[COL_W-1:0];
      cur_row_nxt = (row_in_r > ROW_CLAMP) ? LAST_ROW : row_in_r[ROW_W-1:0];
    end else if (advance) begin
      cur_col_nxt = cur_col_r + 5'd1;
      if (cur_col_r == '1 && cur_row_r != LAST_ROW) cur_row_nxt = cur_row_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      bg_r      <= BG_RESET;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cfg_we) bg_r <= cfg_bg;
    end
  end

  // Double dabble, one bit a cycle
  always_comb begin
    bcd_adj = bcd_r;
    for (int d = 0; d < BCD_W / 4; d++) begin
      if (bcd_r[d*4 +: 4] > 4'd4) bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
    end else if (ctl.conv_start) begin
      bit_cnt_r <= CONV_STEPS;
    end else if (ctl.conv_step) begin
      bit_cnt_r <= bit_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.conv_start) begin
      bcd_r <= '0;
      bin_r <= value_r;
    end else if (ctl.conv_step) begin
      {bcd_r, bin_r} <= {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
    end
  end

  // Write formation
  always_comb begin
    addr_nxt = NAME_BASE + {4'b0, cur_row_r, cur_col_r};
    data_nxt = char_r;
    last_nxt = 1'b1;
    unique case (ctl.wr)
      WR_COLOUR: begin
        addr_nxt = COLOR_BASE + {9'b0, cur_col_r};
        data_nxt = {color_r, bg_r};
        last_nxt = 1'b0;
      end
      WR_HEX: begin
        data_nxt = hex_char(hex_nib);
        last_nxt = (idx_r == '0);
      end
      WR_DEC: begin
        data_nxt = ZERO_CHAR + {4'b0, dec_digit};
        last_nxt = (idx_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.wr != WR_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr != WR_NONE) begin
      out_addr_r <= addr_nxt;
      out_data_r <= data_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  assign status.kind       = kind_r;
  assign status.is_newline = (char_r == NEWLINE);
  assign status.count_zero = count_zero_r;
  assign status.idx_zero   = (idx_r == '0);
  assign status.conv_last  = (bit_cnt_r == 5'd1);
  assign status.out_free   = out_free;
  assign status.dec_emit   = started_r || (dec_digit != 4'd0);

endmodule

`default_nettype wire

### hdl/tcvw_ctrl.sv
// ----------------------------------------------------------------------------
// tcvw_ctrl
// Controller: sequences each command into datapath steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcvw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tcvw_pkg::dp_status_t status,
  output tcvw_pkg::ctl_cmd_t        ctl
);
  import tcvw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (status.kind)
          K_PUT:    state_nxt = status.is_newline ? ST_IDLE : ST_CHAR;
          K_PUT_AT: state_nxt = ST_CHAR;
          K_COLOUR: state_nxt = ST_COLOUR;
          K_HEX:    state_nxt = status.count_zero ? ST_IDLE : ST_HEX;
          K_DEC:    state_nxt = status.count_zero ? ST_IDLE : ST_CONV;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_COLOUR: if (status.out_free) state_nxt = ST_CHAR;
      ST_CHAR:   if (status.out_free) state_nxt = ST_IDLE;
      ST_HEX:    if (status.out_free && status.idx_zero) state_nxt = ST_IDLE;
      ST_CONV:   if (status.conv_last) state_nxt = ST_DEC;
      ST_DEC: begin
        if ((status.out_free || !status.dec_emit) && status.idx_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    ctl.wr   = WR_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_DISPATCH: begin
        unique case (status.kind)
          K_PUT:    ctl.newline    = status.is_newline;
          K_PUT_AT: ctl.place      = 1'b1;
          K_MOVE:   ctl.place      = 1'b1;
          K_DEC:    ctl.conv_start = !status.count_zero;
          default:  ;
        endcase
      end
      ST_COLOUR: if (status.out_free) ctl.wr = WR_COLOUR;
      ST_CHAR:   if (status.out_free) ctl.wr = WR_CHAR;
      ST_HEX:    if (status.out_free) ctl.wr = WR_HEX;
      ST_CONV:   ctl.conv_step = 1'b1;
      ST_DEC: begin
        if (!status.dec_emit)     ctl.dec_skip = 1'b1;
        else if (status.out_free) ctl.wr       = WR_DEC;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hdl/text_console_vram_writer.sv
// ----------------------------------------------------------------------------
// text_console_vram_writer
// 32-column text console: turns console commands into video memory writes.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Item
//   in_cmd   in   valid/ready   kind, char_code, column, row, color, value,
//                               digit_count
//   out_wr   out  valid/ready   vram_address, vram_data, last
//   cfg_wr   in   valid/ready   background_color (always ready)
//
// One command is in flight at a time. Each is accepted, then dispatched,
// then its writes go out in turn: a put makes one write (a newline none),
// a colour put a colour write and then its character, hex one write per
// digit. Decimal first runs the BCD converter, one bit a cycle, then digits.
// The output register frees the controller: a write waiting on out_wr
// stalls only the next write, not the command intake before it.
// Synchronous active-low reset: cursor to home, background colour to 7.
`timescale 1ns / 1ps
`default_nettype none

module text_console_vram_writer (
  input wire logic   clk,
  input wire logic   rst_n,
  tcvw_cmd_if.sink   in_cmd,
  tcvw_wr_if.source  out_wr,
  tcvw_cfg_if.sink   cfg_wr
);
  import tcvw_pkg::*;

  cmd_t       cmd;
  ctl_cmd_t   ctl;
  dp_status_t status;
  logic       in_ready;

  // Pack the command item for the datapath latch
  assign cmd.kind        = in_cmd.kind;
  assign cmd.char_code   = in_cmd.char_code;
  assign cmd.column      = in_cmd.column;
  assign cmd.row         = in_cmd.row;
  assign cmd.color       = in_cmd.color;
  assign cmd.value       = in_cmd.value;
  assign cmd.digit_count = in_cmd.digit_count;

  assign in_cmd.ready = in_ready;

  // The colour register takes a write in any cycle
  assign cfg_wr.ready = 1'b1;

  tcvw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl)
  );

  tcvw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (cmd),
    .cfg_we    (cfg_wr.valid),
    .cfg_bg    (cfg_wr.background_color),
    .ctl       (ctl),
    .status    (status),
    .out_ready (out_wr.ready),
    .out_valid (out_wr.valid),
    .out_addr  (out_wr.vram_address),
    .out_data  (out_wr.vram_data),
    .out_last  (out_wr.last)
  );

endmodule

`default_nettype wire

### hdl/tcvw_checker.sv
// ----------------------------------------------------------------------------
// tcvw_checker
// Port-level checks on the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tcvw_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tcvw_pkg::ADDR_W-1:0] out_addr,
  input wire logic [tcvw_pkg::CHAR_W-1:0] out_data,
  input wire logic                        out_last
);
  import tcvw_pkg::*;

  localparam logic [ADDR_W-1:0] NAME_END  = NAME_BASE + ADDR_W'(ROWS * 32);
  localparam logic [ADDR_W-1:0] COLOR_END = COLOR_BASE + 14'd32;

  logic in_char_area;
  logic in_colour_area;

  assign in_char_area   = (out_addr >= NAME_BASE) && (out_addr < NAME_END);
  assign in_colour_area = (out_addr >= COLOR_BASE) && (out_addr < COLOR_END);

  // Hold a stalled write
  `TCVW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_addr) && $stable(out_data) && $stable(out_last))
  // One command at a time: no intake straight after an accept
  `TCVW_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready)
  // Writes land only in the name table or the colour table
  `TCVW_ASSERT_SAME(a_addr_map, out_valid, in_char_area || in_colour_area)
  // A colour write is never marked last: its character follows
  `TCVW_ASSERT_SAME(a_colour_not_last, out_valid && in_colour_area, !out_last)

endmodule

bind text_console_vram_writer tcvw_checker u_tcvw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_cmd.valid),
  .in_ready  (in_cmd.ready),
  .out_valid (out_wr.valid),
  .out_ready (out_wr.ready),
  .out_addr  (out_wr.vram_address),
  .out_data  (out_wr.vram_data),
  .out_last  (out_wr.last)
);

`default_nettype wire

### sim/tb_text_console_vram_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_vram_writer
// Self-checking bench for the text console video memory writer: drives
// console commands with random gaps, stalls the write channel at random,
// predicts every video memory write from a cursor model of its own and
// compares each accepted write, field by field, in order.
// ----------------------------------------------------------------------------

import tcvw_pkg::*;

typedef struct packed {
  logic [ADDR_W-1:0] addr;
  logic [CHAR_W-1:0] data;
  logic              last;
} vram_wr_t;

// Cursor model plus the queue of video memory writes still to come.
class vram_scoreboard;
  vram_wr_t           pending[$];
  vram_wr_t           batch[$];
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [COLOR_W-1:0] background;
  int                 mismatches;

  function new();
    cur_col    = '0;
    cur_row    = '0;
    background = BG_RESET;
    mismatches = 0;
  endfunction

  function void set_background(logic [COLOR_W-1:0] v);
    background = v;
  endfunction

  // Write at the cursor, then step it: wrap the column, clamp the row.
  function void place_char(logic [CHAR_W-1:0] ch);
    vram_wr_t w;
    w.addr = NAME_BASE + ADDR_W'(cur_row) * 14'd32 + ADDR_W'(cur_col);
    w.data = ch;
    w.last = 1'b0;
    batch.push_back(w);
    if (cur_col == 5'd31) begin
      cur_col = '0;
      if (cur_row < LAST_ROW) cur_row = cur_row + 5'd1;
    end else begin
      cur_col = cur_col + 5'd1;
    end
  endfunction

  function void note_command(cmd_t c);
    logic [COUNT_W-1:0] cnt;
    logic [3:0]         nib;
    vram_wr_t           w;
    int unsigned        shift;
    int unsigned        divisor;
    int unsigned        digit;
    bit                 started;
    int                 i;
    batch.delete();
    cnt = (c.digit_count > MAX_DIGITS) ? MAX_DIGITS : c.digit_count;
    case (c.kind)
      K_PUT: begin
        if (c.char_code == NEWLINE) begin
          cur_col = '0;
          if (cur_row < LAST_ROW) cur_row = cur_row + 5'd1;
        end else begin
          place_char(c.char_code);
        end
      end
      K_PUT_AT, K_MOVE: begin
        cur_col = c.column[COL_W-1:0];
        cur_row = (c.row > ROW_CLAMP) ? LAST_ROW : c.row[ROW_W-1:0];
        if (c.kind == K_PUT_AT) place_char(c.char_code);
      end
      K_COLOUR: begin
        w.addr = COLOR_BASE + ADDR_W'(cur_col);
        w.data = {c.color, background};
        w.last = 1'b0;
        batch.push_back(w);
        place_char(c.char_code);
      end
      K_HEX: begin
        for (i = int'(cnt); i > 0; i--) begin
          shift = (i - 1) * 4;
          nib   = (shift < 16) ? 4'((c.value >> shift) & 16'h000F) : 4'd0;
          if (nib > 4'd9) place_char(ALPHA_A + {4'b0, nib} - 8'd10);
          else            place_char(ZERO_CHAR + {4'b0, nib});
        end
      end
      K_DEC: begin
        divisor = 1;
        started = 1'b0;
        for (i = 1; i < int'(cnt); i++) divisor = divisor * 10;
        if (cnt == 0) divisor = 0;
        while (divisor > 0) begin
          digit = (c.value / divisor) % 10;
          if (digit != 0 || started) begin
            place_char(ZERO_CHAR + 8'(digit));
            started = 1'b1;
          end
          divisor = divisor / 10;
        end
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending.push_back(batch[k]);
  endfunction

  function void check_write(vram_wr_t got);
    vram_wr_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected write: addr %h data %h last %b",
                 got.addr, got.data, got.last);
    end else begin
      want = pending.pop_front();
      if (got.addr !== want.addr || got.data !== want.data || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"write mismatch: expected addr %h data %h last %b, ",
                    "got addr %h data %h last %b"},
                   want.addr, want.data, want.last, got.addr, got.data, got.last);
      end
    end
  endfunction
endclass

module tb_text_console_vram_writer;

  // Unused command codes: the block must drop them silently.
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

  // Decimal with a zero value runs the converter and writes nothing, so
  // allow it to finish before touching the register.
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 76;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;

  tcvw_cmd_if cmd_bus ();
  tcvw_wr_if  wr_bus ();
  tcvw_cfg_if cfg_bus ();

  vram_scoreboard board;

  text_console_vram_writer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_bus),
    .out_wr (wr_bus),
    .cfg_wr (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none in the no-idle phase.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t make_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                    logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                                    logic [COLOR_W-1:0] color,
                                    logic [VALUE_W-1:0] value,
                                    logic [COUNT_W-1:0] count);
    cmd_t c;
    c.kind        = kind;
    c.char_code   = ch;
    c.column      = col;
    c.row         = row;
    c.color       = color;
    c.value       = value;
    c.digit_count = count;
    return c;
  endfunction

  // Weight toward the printing kinds, keep every field random in every kind so
  // that each bit toggles whatever the kind.
  function automatic cmd_t random_command();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 22)      c.kind = K_PUT;
    else if (r < 34) c.kind = K_PUT_AT;
    else if (r < 48) c.kind = K_COLOUR;
    else if (r < 56) c.kind = K_MOVE;
    else if (r < 74) c.kind = K_HEX;
    else if (r < 94) c.kind = K_DEC;
    else             c.kind = ($urandom_range(0, 1) == 0) ? K_SPARE_LO : K_SPARE_HI;
    c.char_code = 8'($urandom_range(0, 255));
    if (c.kind == K_PUT && $urandom_range(0, 7) == 0) c.char_code = NEWLINE;
    c.column = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 31))
                                          : 8'($urandom_range(0, 255));
    c.row    = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 23))
                                          : 8'($urandom_range(0, 255));
    c.color  = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    if (r < 2)      c.value = '0;
    else if (r < 5) c.value = 16'($urandom_range(0, 999));
    else            c.value = 16'($urandom_range(0, 65535));
    c.digit_count = ($urandom_range(0, 19) < 17) ? 3'($urandom_range(1, 5))
                                                 : 3'($urandom_range(0, 7));
    return c;
  endfunction

  // Offer one item and hold it until taken. Leave valid high on return:
  // the next call lowers it only if it wants a gap.
  task automatic send_command(cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.kind        <= c.kind;
    cmd_bus.char_code   <= c.char_code;
    cmd_bus.column      <= c.column;
    cmd_bus.row         <= c.row;
    cmd_bus.color       <= c.color;
    cmd_bus.value       <= c.value;
    cmd_bus.digit_count <= c.digit_count;
    do @(posedge clk); while (!cmd_bus.ready);
    board.note_command(c);
  endtask

  // Drop valid, wait for every predicted write, then let the block settle.
  task automatic drain_console();
    cmd_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_background(logic [COLOR_W-1:0] v);
    cfg_bus.valid            <= 1'b1;
    cfg_bus.background_color <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    board.set_background(v);
  endtask

  task automatic run_directed();
    send_command(make_cmd(K_PUT,    8'h41, 8'd0,   8'd0,   4'd0,  16'h0000, 3'd0));
    // Last column wraps to the next row.
    send_command(make_cmd(K_PUT_AT, 8'h5A, 8'd31,  8'd0,   4'd3,  16'h0000, 3'd1));
    // Column bits above four ignored, row clamped; wrap on the bottom row.
    send_command(make_cmd(K_PUT_AT, 8'hFF, 8'd255, 8'd255, 4'd0,  16'hFFFF, 3'd7));
    // Newline on the bottom row keeps the row.
    send_command(make_cmd(K_PUT,    NEWLINE, 8'd5, 8'd5,   4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_MOVE,   8'h00, 8'd0,   8'd0,   4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_PUT,    NEWLINE, 8'd0, 8'd0,   4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_COLOUR, 8'h00, 8'd0,   8'd0,   4'd15, 16'h0000, 3'd0));
    // A newline code with the colour command is an ordinary character.
    send_command(make_cmd(K_COLOUR, NEWLINE, 8'd0, 8'd0,   4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_PUT_AT, NEWLINE, 8'd30, 8'd22, 4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_HEX,    8'h00, 8'd0,   8'd0,   4'd0,  16'hFFFF, 3'd4));
    // Five nibbles: the top one is beyond the value and prints zero.
    send_command(make_cmd(K_HEX,    8'h00, 8'd0,   8'd0,   4'd0,  16'hA5C3, 3'd5));
    send_command(make_cmd(K_HEX,    8'h00, 8'd0,   8'd0,   4'd0,  16'h1234, 3'd0));
    // Counts above five saturate.
    send_command(make_cmd(K_HEX,    8'h00, 8'd0,   8'd0,   4'd0,  16'h0BEF, 3'd7));
    send_command(make_cmd(K_HEX,    8'h00, 8'd0,   8'd0,   4'd0,  16'h0009, 3'd1));
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'hFFFF, 3'd5));
    // Zero value prints nothing.
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'h0000, 3'd5));
    // Digits above the count are dropped.
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'd12345, 3'd3));
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'd7,    3'd5));
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'd500,  3'd0));
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'd100,  3'd6));
    send_command(make_cmd(K_SPARE_LO, 8'h41, 8'd3, 8'd3,   4'd1,  16'h1111, 3'd2));
    send_command(make_cmd(K_SPARE_HI, 8'h42, 8'd4, 8'd4,   4'd2,  16'h2222, 3'd3));
    send_command(make_cmd(K_MOVE,   8'h00, 8'd200, 8'd30,  4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_PUT,    8'h80, 8'd0,   8'd0,   4'd0,  16'h0000, 3'd0));
    send_command(make_cmd(K_DEC,    8'h00, 8'd0,   8'd0,   4'd0,  16'd10,   3'd2));
  endtask

  // Ignored kinds do not count toward the phase length.
  task automatic run_random(int items);
    cmd_t c;
    int   done;
    done = 0;
    while (done < items) begin
      c = random_command();
      send_command(c);
      if (c.kind <= K_DEC) done++;
    end
  endtask

  // Write channel back-pressure: ready bursts separated by random stalls.
  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        wr_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wr_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Check every write the block hands over.
  always @(posedge clk) begin
    if (rst_n && wr_bus.valid && wr_bus.ready)
      board.check_write('{addr: wr_bus.vram_address, data: wr_bus.vram_data,
                          last: wr_bus.last});
  end

  // Watchdog: end the run if no channel moves an item for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (wr_bus.valid && wr_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [COLOR_W-1:0] settings[4];
    board   = new();
    no_idle = 1'b0;
    rst_n               <= 1'b0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.kind        <= '0;
    cmd_bus.char_code   <= '0;
    cmd_bus.column      <= '0;
    cmd_bus.row         <= '0;
    cmd_bus.color       <= '0;
    cmd_bus.value       <= '0;
    cmd_bus.digit_count <= '0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.background_color <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass runs on the reset background colour.
    run_directed();

    // Random phases, one per background setting, extremes first; the third
    // runs with no idling on either side.
    settings[0] = 4'd0;
    settings[1] = 4'd15;
    settings[2] = 4'($urandom_range(1, 14));
    settings[3] = 4'($urandom_range(0, 15));
    for (int p = 0; p < 4; p++) begin
      drain_console();
      write_background(settings[p]);
      no_idle = (p == 2);
      run_random(PHASE_ITEMS);
    end
    no_idle = 1'b0;
    drain_console();

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tcvw_pkg.sv
hdl/tcvw_cmd_if.sv
hdl/tcvw_wr_if.sv
hdl/tcvw_cfg_if.sv
hdl/tcvw_dp.sv
hdl/tcvw_ctrl.sv
hdl/text_console_vram_writer.sv
hdl/tcvw_checker.sv
sim/tb_text_console_vram_writer.sv
